>>> rtl/core/eacc_pkg.sv
// eacc_pkg: shared constants, CORDIC angle table and sideband structs
// for the elliptical arc center conversion pipeline. No dependencies.
package eacc_pkg;

  localparam int CORDIC_STEPS_DEF  = 24;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int GUARD_BITS        = 6;

  // inverse CORDIC gain, Q0.32
  localparam logic [31:0] INV_GAIN = 32'd2608131496;

  typedef enum logic [1:0] {
    KIND_LINE = 2'd0,
    KIND_NONE = 2'd1,
    KIND_ARC  = 2'd2
  } path_kind_t;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  function automatic logic [31:0] atan_val(input logic [4:0] idx);
    return ATAN_TAB[idx];
  endfunction

  typedef struct packed {
    path_kind_t  kind;
    logic [30:0] rx;
    logic [30:0] ry;
    logic        la;
    logic        sw;
  } rot1_sb_t;

  typedef struct packed {
    logic signed [33:0] xe;
    logic               neg;
    path_kind_t         kind;
    logic [30:0]        rx;
    logic               la;
    logic               sw;
  } div_sb_t;

  typedef struct packed {
    path_kind_t  kind;
    logic [30:0] rx;
    logic [31:0] ratio;
    logic        la;
    logic        sw;
  } vec1_sb_t;

  typedef struct packed {
    path_kind_t  kind;
    logic [31:0] r;
    logic [31:0] h;
    logic [31:0] a;
    logic [31:0] ratio;
    logic        la;
    logic        sw;
  } arc_ctx_t;

endpackage

>>> rtl/core/eacc_cordic.sv
// eacc_cordic: fully pipelined CORDIC, rotation or vectoring mode, with gain
// correction. Depends on eacc_pkg.
module eacc_cordic #(
  parameter int W      = 33,
  parameter bit ROTATE = 1'b1,
  parameter int STEPS  = eacc_pkg::CORDIC_STEPS_DEF,
  parameter int SB_W   = 1
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      valid_i,
  input  logic signed [W-1:0]                       x_i,
  input  logic signed [W-1:0]                       y_i,
  input  logic [31:0]                               ang_i,
  input  logic [SB_W-1:0]                           sb_i,
  output logic                                      valid_o,
  output logic signed [W+eacc_pkg::GUARD_BITS+2:0]  x_o,
  output logic signed [W+eacc_pkg::GUARD_BITS+2:0]  y_o,
  output logic [31:0]                               ang_o,
  output logic [SB_W-1:0]                           sb_o
);
  import eacc_pkg::*;

  localparam int IW = W + GUARD_BITS + 3;
  localparam int ZW = 34;

  logic signed [IW-1:0] xg, yg, x0_nxt, y0_nxt;
  logic signed [ZW-1:0] z0_nxt;
  logic [31:0]          ang_q, ang_h;

  always_comb begin
    xg    = IW'(x_i) <<< GUARD_BITS;
    yg    = IW'(y_i) <<< GUARD_BITS;
    ang_q = ang_i + 32'h4000_0000;
    ang_h = ang_i + 32'h8000_0000;
    if (ROTATE) begin
      // fold into the right half plane first
      if (ang_q[31]) begin
        x0_nxt = -xg;
        y0_nxt = -yg;
        z0_nxt = ZW'($signed(ang_h));
      end else begin
        x0_nxt = xg;
        y0_nxt = yg;
        z0_nxt = ZW'($signed(ang_i));
      end
    end else begin
      if (xg[IW-1]) begin
        x0_nxt = -xg;
        y0_nxt = -yg;
        z0_nxt = 34'sh0_8000_0000;
      end else begin
        x0_nxt = xg;
        y0_nxt = yg;
        z0_nxt = '0;
      end
    end
  end

  logic signed [IW-1:0] x_r  [STEPS+1];
  logic signed [IW-1:0] y_r  [STEPS+1];
  logic signed [ZW-1:0] z_r  [STEPS+1];
  logic                 zr_r [STEPS+1];
  logic                 v_r  [STEPS+1];
  logic [SB_W-1:0]      sb_r [STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]  <= x0_nxt;
    y_r[0]  <= y0_nxt;
    z_r[0]  <= z0_nxt;
    zr_r[0] <= (x_i == '0) && (y_i == '0);
    sb_r[0] <= sb_i;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [IW-1:0] xs, ys;
    logic signed [ZW-1:0] t;
    logic                 pos;

    assign xs  = x_r[i] >>> i;
    assign ys  = y_r[i] >>> i;
    assign t   = ZW'(atan_val(5'(i)));
    assign pos = ROTATE ? ~z_r[i][ZW-1] : (y_r[i][IW-1] || (y_r[i] == '0));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      x_r[i+1]  <= pos ? x_r[i] - ys : x_r[i] + ys;
      y_r[i+1]  <= pos ? y_r[i] + xs : y_r[i] - xs;
      z_r[i+1]  <= pos ? z_r[i] - t : z_r[i] + t;
      zr_r[i+1] <= zr_r[i];
      sb_r[i+1] <= sb_r[i];
    end
  end

  // gain correction: magnitude times INV_GAIN, split into two partial products
  logic [IW-1:0]        mx, my;
  logic [IW-1:0]        phx_r, phy_r;
  logic [63:0]          plx_r, ply_r;
  logic                 sx_r, sy_r, zga_r, vga_r;
  logic signed [ZW-1:0] zga_z_r;
  logic [SB_W-1:0]      sbga_r;

  assign mx = x_r[STEPS][IW-1] ? IW'(-x_r[STEPS]) : IW'(x_r[STEPS]);
  assign my = y_r[STEPS][IW-1] ? IW'(-y_r[STEPS]) : IW'(y_r[STEPS]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vga_r   <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      vga_r   <= v_r[STEPS];
      valid_o <= vga_r;
    end
  end

  logic [IW-1:0] sumx, sumy;
  assign sumx = phx_r + IW'(plx_r[63:32]);
  assign sumy = phy_r + IW'(ply_r[63:32]);

  always_ff @(posedge clk) begin
    phx_r   <= IW'(mx[IW-1:32]) * IW'(INV_GAIN);
    phy_r   <= IW'(my[IW-1:32]) * IW'(INV_GAIN);
    plx_r   <= 64'(mx[31:0]) * 64'(INV_GAIN);
    ply_r   <= 64'(my[31:0]) * 64'(INV_GAIN);
    sx_r    <= x_r[STEPS][IW-1];
    sy_r    <= y_r[STEPS][IW-1];
    zga_r   <= zr_r[STEPS];
    zga_z_r <= z_r[STEPS];
    sbga_r  <= sb_r[STEPS];

    x_o   <= sx_r ? -$signed(sumx) : $signed(sumx);
    y_o   <= sy_r ? -$signed(sumy) : $signed(sumy);
    ang_o <= (!ROTATE && zga_r) ? 32'd0 : zga_z_r[31:0];
    sb_o  <= sbga_r;
  end

endmodule

>>> rtl/core/eacc_div.sv
// eacc_div: pipelined restoring divider, one quotient bit per stage, with
// overflow flag. Depends on eacc_pkg only for the import style.
module eacc_div #(
  parameter int DEN_W = 31,
  parameter int Q_W   = 34,
  parameter int SB_W  = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   valid_i,
  input  logic [Q_W+DEN_W:0]     num_i,
  input  logic [DEN_W-1:0]       den_i,
  input  logic [SB_W-1:0]        sb_i,
  output logic                   valid_o,
  output logic [Q_W-1:0]         q_o,
  output logic                   sat_o,
  output logic [SB_W-1:0]        sb_o
);
  import eacc_pkg::*;

  localparam int RW = DEN_W + 1;

  logic [RW-1:0]    rem_r [Q_W+1];
  logic [Q_W-1:0]   nq_r  [Q_W+1];
  logic [DEN_W-1:0] den_r [Q_W+1];
  logic             sat_r [Q_W+1];
  logic             v_r   [Q_W+1];
  logic [SB_W-1:0]  sb_r  [Q_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= num_i[Q_W+DEN_W:Q_W];
    nq_r[0]  <= num_i[Q_W-1:0];
    den_r[0] <= den_i;
    sat_r[0] <= num_i[Q_W+DEN_W:Q_W] >= RW'(den_i);
    sb_r[0]  <= sb_i;
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_bit
    logic [RW:0] sh, diff;
    logic        ge;

    assign sh   = {rem_r[j], nq_r[j][Q_W-1]};
    assign diff = sh - (RW+1)'(den_r[j]);
    assign ge   = sh >= (RW+1)'(den_r[j]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j+1] <= 1'b0;
      end else begin
        v_r[j+1] <= v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[j+1] <= ge ? diff[RW-1:0] : sh[RW-1:0];
      nq_r[j+1]  <= {nq_r[j][Q_W-2:0], ge};
      den_r[j+1] <= den_r[j];
      sat_r[j+1] <= sat_r[j];
      sb_r[j+1]  <= sb_r[j];
    end
  end

  assign valid_o = v_r[Q_W];
  assign q_o     = nq_r[Q_W];
  assign sat_o   = sat_r[Q_W];
  assign sb_o    = sb_r[Q_W];

endmodule

>>> rtl/core/elliptical_arc_center_conversion_top.sv
// elliptical_arc_center_conversion_top: endpoint-form elliptical arc to
// center form in a local circle frame. Uses eacc_pkg, eacc_cordic, eacc_div.
//
//  channel | ports                                   | transaction
//  --------+-----------------------------------------+-------------------------
//  input   | start, busy, in_*                       | start high, busy low
//  result  | out_valid, out_*                        | out_valid high, 1 cycle
//
// One transaction enters per cycle; busy is always low, the pipeline never
// stops. It is built from three CORDIC pipelines in series (center rotation
// and angle offset run side by side), the 35-stage dividers and the
// 32-stage sqrt.
// Reset (rst_n low, synchronous) clears only the valid bits of every stage.
// The receiver cannot stall; each result appears for exactly one cycle.
module elliptical_arc_center_conversion_top #(
  parameter int CORDIC_STEPS  = eacc_pkg::CORDIC_STEPS_DEF,
  parameter int FRACTION_BITS = eacc_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_current_x,
  input  logic signed [31:0] in_current_y,
  input  logic [30:0]        in_radius_x,
  input  logic [30:0]        in_radius_y,
  input  logic signed [31:0] in_rotation,
  input  logic               in_large_arc,
  input  logic               in_sweep_positive,
  input  logic signed [31:0] in_end_x,
  input  logic signed [31:0] in_end_y,
  output logic               out_valid,
  output logic [1:0]         out_path_kind,
  output logic signed [31:0] out_centre_x,
  output logic signed [31:0] out_centre_y,
  output logic [30:0]        out_arc_radius,
  output logic [31:0]        out_y_ratio,
  output logic signed [31:0] out_start_angle,
  output logic signed [31:0] out_end_angle,
  output logic               out_positive_direction
);
  import eacc_pkg::*;

  localparam int IW_A = 33 + GUARD_BITS + 3;
  localparam int IW_B = 35 + GUARD_BITS + 3;
  localparam logic signed [IW_A:0] WORK_LIM = (IW_A+1)'(64'sd8589934591);
  localparam logic signed [IW_A:0] OUT_MAX  = (IW_A+1)'(64'sd2147483647);
  localparam logic signed [IW_A:0] OUT_MIN  = (IW_A+1)'(-64'sd2147483648);
  localparam logic signed [IW_B:0] HALF_LIM = (IW_B+1)'(64'sd4294967295);
  localparam logic [33:0]          Q_LIM    = 34'h1_FFFF_FFFF;
  localparam logic [33:0]          R_LIM    = 34'h0_FFFF_FFFF;

  assign busy = 1'b0;

  // ---------------- stage 0: capture, special cases, chord vector
  path_kind_t         kind0_nxt;
  logic               v0_r;
  logic signed [32:0] dx0_r, dy0_r;
  logic [31:0]        nrot0_r;
  rot1_sb_t           sb0_r;

  always_comb begin
    if (in_radius_x == '0 || in_radius_y == '0) begin
      kind0_nxt = KIND_LINE;
    end else if (in_current_x == in_end_x && in_current_y == in_end_y) begin
      kind0_nxt = KIND_NONE;
    end else begin
      kind0_nxt = KIND_ARC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    dx0_r      <= 33'(in_end_x) - 33'(in_current_x);
    dy0_r      <= 33'(in_end_y) - 33'(in_current_y);
    nrot0_r    <= 32'd0 - in_rotation;
    sb0_r.kind <= kind0_nxt;
    sb0_r.rx   <= in_radius_x;
    sb0_r.ry   <= in_radius_y;
    sb0_r.la   <= in_large_arc;
    sb0_r.sw   <= in_sweep_positive;
  end

  // ---------------- rotate chord by -rotation
  logic                  r1_v;
  logic signed [IW_A-1:0] r1_x, r1_y;
  rot1_sb_t              r1_sb;

  eacc_cordic #(
    .W(33), .ROTATE(1'b1), .STEPS(CORDIC_STEPS), .SB_W($bits(rot1_sb_t))
  ) u_rot1 (
    .clk(clk), .rst_n(rst_n), .valid_i(v0_r), .x_i(dx0_r), .y_i(dy0_r),
    .ang_i(nrot0_r), .sb_i(sb0_r), .valid_o(r1_v), .x_o(r1_x), .y_o(r1_y),
    .ang_o(), .sb_o(r1_sb)
  );

  // ---------------- stage 1: round off guard bits, clamp to work range
  logic signed [IW_A:0] ux1, uy1, cx1, cy1, ay1;
  logic                 v1_r, neg1_r;
  logic signed [33:0]   xe1_r;
  logic [32:0]          mag1_r;
  rot1_sb_t             sb1_r;

  always_comb begin
    ux1 = ((IW_A+1)'(r1_x) + (IW_A+1)'(32)) >>> GUARD_BITS;
    uy1 = ((IW_A+1)'(r1_y) + (IW_A+1)'(32)) >>> GUARD_BITS;
    cx1 = (ux1 > WORK_LIM) ? WORK_LIM : ((ux1 < -WORK_LIM) ? -WORK_LIM : ux1);
    cy1 = (uy1 > WORK_LIM) ? WORK_LIM : ((uy1 < -WORK_LIM) ? -WORK_LIM : uy1);
    ay1 = cy1[IW_A] ? -cy1 : cy1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= r1_v;
    end
  end

  always_ff @(posedge clk) begin
    xe1_r  <= cx1[33:0];
    neg1_r <= cy1[IW_A];
    mag1_r <= ay1[32:0];
    sb1_r  <= r1_sb;
  end

  // ---------------- stage 2: |ye| * radius_x as two partial products
  logic               v2_r, neg2_r;
  logic signed [33:0] xe2_r;
  logic [47:0]        php2_r;
  logic [46:0]        plp2_r;
  logic [65:0]        rnum2_r;
  rot1_sb_t           sb2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    php2_r  <= 48'(mag1_r[32:16]) * 48'(sb1_r.rx);
    plp2_r  <= 47'(mag1_r[15:0]) * 47'(sb1_r.rx);
    rnum2_r <= 66'(sb1_r.ry) << FRACTION_BITS;
    xe2_r   <= xe1_r;
    neg2_r  <= neg1_r;
    sb2_r   <= sb1_r;
  end

  // ---------------- stage 3: sum the partial products
  logic      v3_r;
  logic [65:0] num3_r, rnum3_r;
  div_sb_t   dsb3_r;
  logic [30:0] rx3_r, ry3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    num3_r      <= (66'(php2_r) << 16) + 66'(plp2_r);
    rnum3_r     <= rnum2_r;
    rx3_r       <= sb2_r.rx;
    ry3_r       <= sb2_r.ry;
    dsb3_r.xe   <= xe2_r;
    dsb3_r.neg  <= neg2_r;
    dsb3_r.kind <= sb2_r.kind;
    dsb3_r.rx   <= sb2_r.rx;
    dsb3_r.la   <= sb2_r.la;
    dsb3_r.sw   <= sb2_r.sw;
  end

  // ---------------- dividers: ye*rx/ry and the y ratio, side by side
  logic        dq_v, dq_sat, dr_sat;
  logic [33:0] dq_q, dr_q;
  div_sb_t     dq_sb;

  eacc_div #(.DEN_W(31), .Q_W(34), .SB_W($bits(div_sb_t))) u_div_y (
    .clk(clk), .rst_n(rst_n), .valid_i(v3_r), .num_i(num3_r), .den_i(ry3_r),
    .sb_i(dsb3_r), .valid_o(dq_v), .q_o(dq_q), .sat_o(dq_sat), .sb_o(dq_sb)
  );

  eacc_div #(.DEN_W(31), .Q_W(34), .SB_W(1)) u_div_ratio (
    .clk(clk), .rst_n(rst_n), .valid_i(v3_r), .num_i(rnum3_r), .den_i(rx3_r),
    .sb_i(1'b0), .valid_o(), .q_o(dr_q), .sat_o(dr_sat), .sb_o()
  );

  // ---------------- stage 4: saturate quotients, restore sign
  logic [33:0]        qm4;
  logic               v4_r;
  logic signed [34:0] xe4_r, ye4_r;
  vec1_sb_t           sb4_r;

  assign qm4 = (dq_sat || dq_q > Q_LIM) ? Q_LIM : dq_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= dq_v;
    end
  end

  always_ff @(posedge clk) begin
    xe4_r       <= 35'($signed(dq_sb.xe));
    ye4_r       <= dq_sb.neg ? -$signed(35'(qm4)) : $signed(35'(qm4));
    sb4_r.kind  <= dq_sb.kind;
    sb4_r.rx    <= dq_sb.rx;
    sb4_r.ratio <= (dr_sat || dr_q > R_LIM) ? 32'hFFFF_FFFF : dr_q[31:0];
    sb4_r.la    <= dq_sb.la;
    sb4_r.sw    <= dq_sb.sw;
  end

  // ---------------- vectoring: chord angle and length
  logic                   c1_v;
  logic signed [IW_B-1:0] c1_x;
  logic [31:0]            c1_ang;
  vec1_sb_t               c1_sb;

  eacc_cordic #(
    .W(35), .ROTATE(1'b0), .STEPS(CORDIC_STEPS), .SB_W($bits(vec1_sb_t))
  ) u_vec1 (
    .clk(clk), .rst_n(rst_n), .valid_i(v4_r), .x_i(xe4_r), .y_i(ye4_r),
    .ang_i(32'd0), .sb_i(sb4_r), .valid_o(c1_v), .x_o(c1_x), .y_o(),
    .ang_o(c1_ang), .sb_o(c1_sb)
  );

  // ---------------- stage 5: half chord; sub-LSB chord taken as zero
  logic signed [IW_B:0] ug5, hv5;
  logic                 v5_r;
  arc_ctx_t             ctx5_r;

  assign ug5 = ((IW_B+1)'(c1_x) + (IW_B+1)'(32)) >>> GUARD_BITS;
  assign hv5 = ((IW_B+1)'(c1_x) + (IW_B+1)'(64)) >>> (GUARD_BITS + 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= c1_v;
    end
  end

  always_ff @(posedge clk) begin
    ctx5_r.kind  <= c1_sb.kind;
    ctx5_r.r     <= 32'(c1_sb.rx);
    ctx5_r.ratio <= c1_sb.ratio;
    ctx5_r.la    <= c1_sb.la;
    ctx5_r.sw    <= c1_sb.sw;
    if (ug5 == '0) begin
      ctx5_r.h <= '0;
      ctx5_r.a <= '0;
    end else begin
      ctx5_r.h <= (hv5 > HALF_LIM) ? 32'hFFFF_FFFF : hv5[31:0];
      ctx5_r.a <= c1_ang;
    end
  end

  // ---------------- stage 6: enlarge radius to at least half the chord
  logic     v6_r;
  arc_ctx_t ctx6_nxt, ctx6_r;

  always_comb begin
    ctx6_nxt   = ctx5_r;
    ctx6_nxt.r = (ctx5_r.r > ctx5_r.h) ? ctx5_r.r : ctx5_r.h;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    ctx6_r <= ctx6_nxt;
  end

  // ---------------- stage 7: squares
  logic        v7_r;
  logic [63:0] rr7_r, hh7_r;
  arc_ctx_t    ctx7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    rr7_r  <= 64'(ctx6_r.r) * 64'(ctx6_r.r);
    hh7_r  <= 64'(ctx6_r.h) * 64'(ctx6_r.h);
    ctx7_r <= ctx6_r;
  end

  // ---------------- stage 8 and sqrt pipeline, one root bit per stage
  logic [63:0] sq_rem_r [33];
  logic [31:0] sq_q_r   [33];
  logic        sq_v_r   [33];
  arc_ctx_t    sq_ctx_r [33];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else begin
      sq_v_r[0] <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    sq_rem_r[0] <= rr7_r - hh7_r;
    sq_q_r[0]   <= '0;
    sq_ctx_r[0] <= ctx7_r;
  end

  for (genvar j = 0; j < 32; j++) begin : g_sqrt
    localparam int K = 31 - j;
    logic [64:0] t, rem_x;
    logic        ge;

    assign t     = (65'(sq_q_r[j]) << (K + 1)) | (65'(1) << (2 * K));
    assign rem_x = {1'b0, sq_rem_r[j]};
    assign ge    = rem_x >= t;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[j+1] <= 1'b0;
      end else begin
        sq_v_r[j+1] <= sq_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      sq_rem_r[j+1] <= ge ? 64'(rem_x - t) : sq_rem_r[j];
      sq_q_r[j+1]   <= ge ? (sq_q_r[j] | (32'd1 << K)) : sq_q_r[j];
      sq_ctx_r[j+1] <= sq_ctx_r[j];
    end
  end

  // ---------------- stage 9: mirror center when large_arc equals sweep
  logic               v9_r;
  logic signed [32:0] ycs9_r, nycs9_r, h9_r;
  arc_ctx_t           ctx9_r;
  logic signed [32:0] yc9;

  assign yc9 = $signed(33'(sq_q_r[32]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else begin
      v9_r <= sq_v_r[32];
    end
  end

  always_ff @(posedge clk) begin
    if (sq_ctx_r[32].la == sq_ctx_r[32].sw) begin
      ycs9_r  <= -yc9;
      nycs9_r <= yc9;
    end else begin
      ycs9_r  <= yc9;
      nycs9_r <= -yc9;
    end
    h9_r   <= $signed(33'(sq_ctx_r[32].h));
    ctx9_r <= sq_ctx_r[32];
  end

  // ---------------- center rotation and angle offset, in parallel
  logic                   c2_v;
  logic signed [IW_A-1:0] c2_x, c2_y;
  logic [31:0]            c3_ang;
  arc_ctx_t               c2_ctx;

  eacc_cordic #(
    .W(33), .ROTATE(1'b1), .STEPS(CORDIC_STEPS), .SB_W($bits(arc_ctx_t))
  ) u_rot2 (
    .clk(clk), .rst_n(rst_n), .valid_i(v9_r), .x_i(h9_r), .y_i(ycs9_r),
    .ang_i(ctx9_r.a), .sb_i(ctx9_r), .valid_o(c2_v), .x_o(c2_x), .y_o(c2_y),
    .ang_o(), .sb_o(c2_ctx)
  );

  eacc_cordic #(
    .W(33), .ROTATE(1'b0), .STEPS(CORDIC_STEPS), .SB_W(1)
  ) u_vec2 (
    .clk(clk), .rst_n(rst_n), .valid_i(v9_r), .x_i(h9_r), .y_i(nycs9_r),
    .ang_i(32'd0), .sb_i(1'b0), .valid_o(), .x_o(), .y_o(),
    .ang_o(c3_ang), .sb_o()
  );

  // ---------------- output stage: round, clamp, assemble result
  logic signed [IW_A:0] ux10, uy10;
  logic                 arc10;
  logic                 vo_r, dir_r;
  logic [1:0]           kind_r;
  logic signed [31:0]   cx_r, cy_r, sa_r, ea_r;
  logic [30:0]          rad_r;
  logic [31:0]          ratio_r;

  assign ux10  = ((IW_A+1)'(c2_x) + (IW_A+1)'(32)) >>> GUARD_BITS;
  assign uy10  = ((IW_A+1)'(c2_y) + (IW_A+1)'(32)) >>> GUARD_BITS;
  assign arc10 = (c2_ctx.kind == KIND_ARC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= c2_v;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= c2_ctx.kind;
    if (arc10) begin
      cx_r    <= (ux10 > OUT_MAX) ? 32'sh7FFF_FFFF :
                 ((ux10 < OUT_MIN) ? 32'sh8000_0000 : ux10[31:0]);
      cy_r    <= (uy10 > OUT_MAX) ? 32'sh7FFF_FFFF :
                 ((uy10 < OUT_MIN) ? 32'sh8000_0000 : uy10[31:0]);
      rad_r   <= c2_ctx.r[31] ? 31'h7FFF_FFFF : c2_ctx.r[30:0];
      ratio_r <= c2_ctx.ratio;
      sa_r    <= c2_ctx.a + 32'h8000_0000 - c3_ang;
      ea_r    <= c2_ctx.a + c3_ang;
      dir_r   <= c2_ctx.sw;
    end else begin
      cx_r    <= '0;
      cy_r    <= '0;
      rad_r   <= '0;
      ratio_r <= '0;
      sa_r    <= '0;
      ea_r    <= '0;
      dir_r   <= 1'b0;
    end
  end

  assign out_valid              = vo_r;
  assign out_path_kind          = kind_r;
  assign out_centre_x           = cx_r;
  assign out_centre_y           = cy_r;
  assign out_arc_radius         = rad_r;
  assign out_y_ratio            = ratio_r;
  assign out_start_angle        = sa_r;
  assign out_end_angle          = ea_r;
  assign out_positive_direction = dir_r;

endmodule

>>> tb/elliptical_arc_center_conversion_top_test.sv
// Self-checking testbench for elliptical_arc_center_conversion_top: random and
// directed arc elements, bit-exact fixed-point CORDIC predictor, in-order check.
// Depends on eacc_pkg (path kinds, GUARD_BITS, INV_GAIN, angle table).
module elliptical_arc_center_conversion_top_test;
  import eacc_pkg::*;

  localparam int STEPS        = CORDIC_STEPS_DEF;
  localparam int FRAC         = FRACTION_BITS_DEF;
  localparam int LATENCY      = 3 * STEPS + 87;
  localparam int WATCH_LIMIT  = 20 * LATENCY + 200;
  localparam longint WORK_LIM = 64'sd8589934591;
  localparam longint HALF_LIM = 64'sd4294967295;

  typedef struct {
    logic signed [31:0] cx, cy;
    logic [30:0]        rx, ry;
    logic signed [31:0] rot;
    logic               la, sw;
    logic signed [31:0] ex, ey;
  } arc_elem_t;

  typedef struct {
    path_kind_t         kind;
    logic signed [31:0] ccx, ccy;
    logic [30:0]        rad;
    logic [31:0]        ratio;
    logic signed [31:0] ang_s, ang_e;
    logic               dir;
  } arc_geom_t;

  logic clk, rst_n, start, busy;
  logic signed [31:0] in_current_x, in_current_y, in_rotation, in_end_x, in_end_y;
  logic [30:0] in_radius_x, in_radius_y;
  logic in_large_arc, in_sweep_positive;
  logic out_valid;
  logic [1:0] out_path_kind;
  logic signed [31:0] out_centre_x, out_centre_y, out_start_angle, out_end_angle;
  logic [30:0] out_arc_radius;
  logic [31:0] out_y_ratio;
  logic out_positive_direction;

  elliptical_arc_center_conversion_top dut (.*);

  arc_elem_t pending_elems[$];
  arc_geom_t expected_geoms[$];
  int  mismatches = 0;
  int  quiet_cycles = 0;
  bit  stim_done = 0;
  bit  no_idle = 0;
  int  idle_left = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // ---------------- predictor: fixed-point helpers ----------------
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;  // arithmetic shift is a floor on signed
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // scale by inverse CORDIC gain, magnitude truncated
  function automatic longint apply_gain(longint a);
    logic [63:0] m, r;
    m = a < 0 ? -a : a;
    r = (m >> 32) * INV_GAIN + (((m & 64'hFFFF_FFFF) * INV_GAIN) >> 32);
    return a < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint drop_guard(longint v);
    return floor_shr(v + (64'sd1 <<< (GUARD_BITS - 1)), GUARD_BITS);
  endfunction

  function automatic void rotate_vec(inout longint px, inout longint py,
                                     input logic [31:0] ang);
    longint x, y, z, xs, ys;
    logic [31:0] probe;
    x = px <<< GUARD_BITS;
    y = py <<< GUARD_BITS;
    probe = ang + 32'h4000_0000;
    if (probe[31]) begin
      x = -x; y = -y;
      ang = ang + 32'h8000_0000;
    end
    z = longint'(signed'(ang));
    for (int i = 0; i < STEPS; i++) begin
      xs = floor_shr(x, i % 32);
      ys = floor_shr(y, i % 32);
      if (z >= 0) begin
        x -= ys; y += xs; z -= ATAN_TAB[i % 32];
      end else begin
        x += ys; y -= xs; z += ATAN_TAB[i % 32];
      end
    end
    px = drop_guard(apply_gain(x));
    py = drop_guard(apply_gain(y));
  endfunction

  function automatic logic [31:0] vector_angle(longint x, longint y, output longint mag);
    logic [31:0] ang;
    longint xs, ys;
    ang = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    x = x <<< GUARD_BITS;
    y = y <<< GUARD_BITS;
    if (x < 0) begin
      x = -x; y = -y; ang = 32'h8000_0000;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = floor_shr(x, i % 32);
      ys = floor_shr(y, i % 32);
      if (y > 0) begin
        x += ys; y -= xs; ang = ang + ATAN_TAB[i % 32];
      end else begin
        x -= ys; y += xs; ang = ang - ATAN_TAB[i % 32];
      end
    end
    mag = apply_gain(x);
    return ang;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  // endpoint form -> centre form in the local circle frame
  function automatic arc_geom_t convert_arc(arc_elem_t t);
    arc_geom_t g;
    longint xe, ye, lg, h, ccx, ccy, ycs;
    logic [63:0] m, q, r, yc, ratio;
    logic [31:0] a, e;
    g = '{kind: KIND_LINE, default: '0};
    if (t.rx == 0 || t.ry == 0) return g;
    if (t.cx == t.ex && t.cy == t.ey) begin
      g.kind = KIND_NONE;
      return g;
    end
    xe = longint'(t.ex) - longint'(t.cx);
    ye = longint'(t.ey) - longint'(t.cy);
    rotate_vec(xe, ye, -t.rot);
    xe = clip(xe, -WORK_LIM, WORK_LIM);
    ye = clip(ye, -WORK_LIM, WORK_LIM);
    m = ye < 0 ? -ye : ye;
    q = m * t.rx / t.ry;
    if (q > WORK_LIM) q = WORK_LIM;
    ye = ye < 0 ? -longint'(q) : longint'(q);
    a = vector_angle(xe, ye, lg);
    if (drop_guard(lg) == 0) begin
      h = 0; a = 0;   // chord below one LSB counts as zero
    end else begin
      h = floor_shr(lg + (64'sd1 <<< GUARD_BITS), GUARD_BITS + 1);
      if (h > HALF_LIM) h = HALF_LIM;
    end
    r = (t.rx > h) ? 64'(t.rx) : 64'(h);
    yc = int_sqrt(r * r - 64'(h) * 64'(h));
    ycs = (t.la == t.sw) ? -longint'(yc) : longint'(yc);
    e = vector_angle(h, -ycs, lg);
    ccx = h;
    ccy = ycs;
    rotate_vec(ccx, ccy, a);
    ratio = (64'(t.ry) << FRAC) / t.rx;
    g.kind  = KIND_ARC;
    g.ccx   = 32'(clip(ccx, -64'sd2147483648, 64'sd2147483647));
    g.ccy   = 32'(clip(ccy, -64'sd2147483648, 64'sd2147483647));
    g.rad   = r > 64'h7FFF_FFFF ? 31'h7FFF_FFFF : 31'(r);
    g.ratio = ratio > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : 32'(ratio);
    g.ang_s = a + 32'h8000_0000 - e;
    g.ang_e = a + e;
    g.dir   = t.sw;
    return g;
  endfunction

  // ---------------- stimulus generation ----------------
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;                                   // full range
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return 32'(signed'($urandom_range(0, 4000)) - 2000);  // tiny
      default: return 32'(signed'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000);
    endcase
  endfunction

  function automatic logic [30:0] rand_radius();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 31'h7FFF_FFFF;
      2: return $urandom_range(1, 50);
      3: return 31'($urandom);
      default: return $urandom_range(1, 32'h0080_0000);
    endcase
  endfunction

  function automatic arc_elem_t rand_elem();
    arc_elem_t t;
    t.cx = rand_coord(); t.cy = rand_coord();
    t.rx = rand_radius(); t.ry = rand_radius();
    if ($urandom_range(0, 9) < 8 && t.rx == 0) t.rx = $urandom_range(1, 32'h0010_0000);
    if ($urandom_range(0, 9) < 8 && t.ry == 0) t.ry = $urandom_range(1, 32'h0010_0000);
    t.rot = $urandom;
    t.la = $urandom_range(0, 1); t.sw = $urandom_range(0, 1);
    case ($urandom_range(0, 9))
      0: begin t.ex = t.cx; t.ey = t.cy; end               // coincident
      1: begin t.ex = t.cx + $urandom_range(0, 1); t.ey = t.cy; end  // sub-LSB chord
      2, 3: begin                                           // chord near radius_x
        t.ex = t.cx + 32'(t.rx[29:0]) + $urandom_range(0, 8) - 4;
        t.ey = t.cy;
      end
      default: begin t.ex = rand_coord(); t.ey = rand_coord(); end
    endcase
    return t;
  endfunction

  function automatic arc_elem_t mk(logic [31:0] cx, cy, logic [30:0] rx, ry,
                                   logic [31:0] rot, logic la, sw,
                                   logic [31:0] ex, ey);
    arc_elem_t t;
    t = '{cx, cy, rx, ry, rot, la, sw, ex, ey};
    return t;
  endfunction

  initial begin
    // directed: line, none, all flag combos, extremes, small radius, sub-LSB chord
    pending_elems.push_back(mk(0, 0, 0, 1 << 16, 0, 0, 0, 1 << 16, 0));
    pending_elems.push_back(mk(5, 5, 1 << 16, 0, 0, 1, 1, 7, 9));
    pending_elems.push_back(mk(32'h1234, 32'h5678, 1 << 16, 1 << 16, 0, 0, 0,
                               32'h1234, 32'h5678));
    for (int f = 0; f < 4; f++)
      pending_elems.push_back(mk(0, 0, 1 << 16, 2 << 16, 32'h2000_0000, f[1], f[0],
                                 1 << 16, 1 << 16));
    pending_elems.push_back(mk(0, 0, 10, 10, 0, 1, 0, 32'h0100_0000, 0));
    pending_elems.push_back(mk(0, 0, 1 << 16, 1 << 16, 0, 0, 1, 1, 0));
    pending_elems.push_back(mk(0, 0, 1 << 16, 1 << 16, 0, 1, 1, 0, 1));
    pending_elems.push_back(mk(32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                               32'h8000_0000, 1, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    pending_elems.push_back(mk(32'h7FFF_FFFF, 32'h8000_0000, 1, 31'h7FFF_FFFF,
                               32'h7FFF_FFFF, 0, 1, 32'h8000_0000, 32'h7FFF_FFFF));
    pending_elems.push_back(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1,
                               32'hFFFF_FFFF, 1, 1, 0, 0));
    pending_elems.push_back(mk(0, 0, 1, 1, 32'h4000_0000, 0, 0, 32'hFFFF_0000, 32'h0001_0000));
    pending_elems.push_back(mk(0, 0, 2 << 16, 1 << 16, 32'hC000_0000, 1, 0,
                               4 << 16, 0));
    for (int i = 0; i < 1000; i++) pending_elems.push_back(rand_elem());
  end

  // ---------------- driver ----------------
  task automatic drive_elem(arc_elem_t t);
    in_current_x <= t.cx; in_current_y <= t.cy;
    in_radius_x <= t.rx; in_radius_y <= t.ry;
    in_rotation <= t.rot;
    in_large_arc <= t.la; in_sweep_positive <= t.sw;
    in_end_x <= t.ex; in_end_y <= t.ey;
  endtask

  initial begin
    rst_n = 0; start = 0;
    in_current_x = 0; in_current_y = 0; in_radius_x = 0; in_radius_y = 0;
    in_rotation = 0; in_large_arc = 0; in_sweep_positive = 0; in_end_x = 0; in_end_y = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
  end

  // Accept at the edge where start && !busy; then decide what goes on the bus next.
  always @(posedge clk) begin
    arc_elem_t nxt;
    if (rst_n) begin
      if (start && !busy) expected_geoms.push_back(convert_arc(pending_elems.pop_front()));
      no_idle <= pending_elems.size() < 150;   // last stretch runs back to back
      if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        start <= 0;
      end else if (start && !busy || !start) begin
        if (pending_elems.size() == 0) begin
          start <= 0;
          stim_done <= 1;
        end else if (!no_idle && $urandom_range(0, 15) == 0) begin
          idle_left <= $urandom_range(0, 6);   // idle burst of random length
          start <= 0;
        end else begin
          nxt = pending_elems[0];
          drive_elem(nxt);
          start <= 1;
        end
      end
    end
  end

  // ---------------- monitor / checker ----------------
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h (t=%0t)", what, got, want, $time);
    mismatches++;
  endtask

  always @(posedge clk) begin
    arc_geom_t w;
    if (rst_n && out_valid) begin
      if (expected_geoms.size() == 0) report_mismatch("unexpected transaction", 0, 0);
      else begin
        w = expected_geoms.pop_front();
        if (out_path_kind !== w.kind) report_mismatch("path_kind", out_path_kind, w.kind);
        if (out_centre_x !== w.ccx) report_mismatch("centre_x", out_centre_x, w.ccx);
        if (out_centre_y !== w.ccy) report_mismatch("centre_y", out_centre_y, w.ccy);
        if (out_arc_radius !== w.rad) report_mismatch("arc_radius", out_arc_radius, w.rad);
        if (out_y_ratio !== w.ratio) report_mismatch("y_ratio", out_y_ratio, w.ratio);
        if (out_start_angle !== w.ang_s)
          report_mismatch("start_angle", out_start_angle, w.ang_s);
        if (out_end_angle !== w.ang_e) report_mismatch("end_angle", out_end_angle, w.ang_e);
        if (out_positive_direction !== w.dir)
          report_mismatch("positive_direction", out_positive_direction, w.dir);
      end
    end
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCH_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (expected_geoms.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
